### rtl/core/pbra_pkg.sv
// ----------------------------------------------------------------------------
// Page bitmap run allocator package
// Command and status codes, field widths and word types shared by the
// allocator and its checker.
// ----------------------------------------------------------------------------
package pbra_pkg;

  localparam int WORD_W  = 32;
  localparam int WBIT_W  = 5;
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 11;
  localparam int LEN_W   = 11;
  localparam int START_W = 10;
  localparam int CNT_W   = 11;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [1:0]        status_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam cmd_t CMD_CLAIM   = 2'd0;
  localparam cmd_t CMD_RELEASE = 2'd1;
  localparam cmd_t CMD_ALLOC   = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_EXISTS  = 2'd2;
  localparam status_t ST_NOSPACE = 2'd3;

endpackage

### rtl/core/page_bitmap_run_allocator.sv
// ----------------------------------------------------------------------------
// Page bitmap run allocator
// Keeps an allocation bitmap of ENTRIES pages in a word memory and claims,
// releases or allocates first-fit contiguous runs of pages.
//
//   Channel  Handshake            Word
//   input    start, busy          in_command, in_page_index, in_run_length
//   result   out_valid (strobe)   out_status, out_run_start, out_allocated_count
//
// Claim and release read the page's word when accepted and update it in the bit
// state. An allocate that is rejected up front or an unused command answers in the
// next cycle. An allocate reads the map one 32-bit word per cycle through a single
// scan unit, then rewrites the words of the run one per cycle.
// Reset clears the map at once through per-word valid flags; no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module page_bitmap_run_allocator #(
  parameter int ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pbra_pkg::cmd_t      in_command,
  input  logic [10:0]         in_page_index,
  input  logic [10:0]         in_run_length,
  output logic                out_valid,
  output pbra_pkg::status_t   out_status,
  output logic [9:0]          out_run_start,
  output logic [10:0]         out_allocated_count
);
  import pbra_pkg::*;

  localparam int WORDS = (ENTRIES + WORD_W - 1) / WORD_W;
  localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TAIL  = ENTRIES % WORD_W;
  localparam word_t LAST_MASK = (TAIL == 0) ? '0 : ~((word_t'(1) << TAIL) - word_t'(1));

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BIT  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FPRE = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;

  function automatic logic [5:0] trail_zeros(word_t w);
    logic [5:0] n;
    logic       hit;
    n   = 6'd32;
    hit = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!hit && w[i]) begin
        n   = 6'(i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lead_zeros(word_t w);
    logic [5:0] n;
    logic       hit;
    n   = 6'd32;
    hit = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!hit && w[WORD_W-1-i]) begin
        n   = 6'(i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Bit i is set when bits i to i+l-1 of w are all clear inside the word.
  function automatic word_t run_mask(word_t w, logic [5:0] l);
    word_t p;
    word_t acc;
    logic  seeded;
    p      = ~w;
    acc    = '1;
    seeded = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (l[k]) begin
        acc    = seeded ? (p & (acc >> (1 << k))) : p;
        seeded = 1'b1;
      end
      p = p & (p >> (1 << k));
    end
    return acc;
  endfunction

  function automatic logic [WBIT_W-1:0] first_set(word_t w);
    logic [WBIT_W-1:0] n;
    logic              hit;
    n   = '0;
    hit = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!hit && w[i]) begin
        n   = WBIT_W'(i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  word_t            mem [WORDS];
  logic [WORDS-1:0] wvalid_r;
  word_t            rdata_r;
  logic             rvalid_r;

  logic [2:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [10:0]      idx_r, idx_nxt;
  logic [10:0]      len_r, len_nxt;
  logic [WA_W-1:0]  addr_r, addr_nxt;
  logic [WA_W-1:0]  word_r, word_nxt;
  logic [10:0]      run_r, run_nxt;
  logic [10:0]      start_r, start_nxt;
  logic [10:0]      end_r, end_nxt;
  logic [10:0]      count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [9:0]       out_start_r, out_start_nxt;

  logic [WA_W-1:0]  rd_addr;
  logic             we;
  logic [WA_W-1:0]  wa;
  word_t            wd;

  word_t            rd_word;
  word_t            scan_w;
  word_t            fit;
  word_t            bmask;
  word_t            fmask;
  logic [5:0]       tz;
  logic [5:0]       lz;
  logic             carry_hit;
  logic             in_hit;
  logic [10:0]      base;
  logic [10:0]      found_start;
  logic [WA_W-1:0]  start_w;
  logic [WA_W-1:0]  end_w;
  logic [4:0]       lo;
  logic [4:0]       hi;

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_run_start       = out_start_r;
  assign out_allocated_count = count_r;

  assign rd_word   = rvalid_r ? rdata_r : '0;
  assign scan_w    = rd_word | ((word_r == WA_W'(WORDS - 1)) ? LAST_MASK : '0);
  assign tz        = trail_zeros(scan_w);
  assign lz        = lead_zeros(scan_w);
  assign fit       = run_mask(scan_w, len_r[5:0]);
  assign carry_hit = ({1'b0, run_r} + 12'(tz)) >= {1'b0, len_r};
  assign in_hit    = (len_r[10:6] == '0) && (|fit);
  assign base      = 11'({word_r, 5'd0});
  assign found_start = carry_hit ? (base - run_r) : (base | 11'(first_set(fit)));
  assign bmask     = word_t'(1) << idx_r[4:0];
  assign start_w   = start_r[WA_W+4:5];
  assign end_w     = end_r[WA_W+4:5];
  assign lo        = (word_r == start_w) ? start_r[4:0] : 5'd0;
  assign hi        = (word_r == end_w) ? end_r[4:0] : 5'd31;
  assign fmask     = (word_t'('1) << lo) & (word_t'('1) >> (5'd31 - hi));

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    addr_nxt       = addr_r;
    word_nxt       = word_r;
    run_nxt        = run_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    rd_addr        = addr_r;
    we             = 1'b0;
    wa             = word_r;
    wd             = rd_word;
    case (state_r)
      S_IDLE: begin
        rd_addr = (in_command == CMD_ALLOC) ? '0 : in_page_index[WA_W+4:5];
        if (start) begin
          cmd_nxt = in_command;
          idx_nxt = in_page_index;
          len_nxt = in_run_length;
          case (in_command)
            CMD_CLAIM, CMD_RELEASE: begin
              state_nxt = S_BIT;
            end
            CMD_ALLOC: begin
              if (in_run_length == '0 || in_run_length > LEN_W'(ENTRIES)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_NOSPACE;
                out_start_nxt  = '0;
              end else begin
                state_nxt = S_SCAN;
                addr_nxt  = WA_W'(1);
                word_nxt  = '0;
                run_nxt   = '0;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_INVALID;
              out_start_nxt  = '0;
            end
          endcase
        end
      end
      S_BIT: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_start_nxt = '0;
        wa            = idx_r[WA_W+4:5];
        if (idx_r >= IDX_W'(ENTRIES)) begin
          out_status_nxt = ST_INVALID;
        end else if (cmd_r == CMD_CLAIM) begin
          if (rd_word[idx_r[4:0]]) begin
            out_status_nxt = ST_EXISTS;
          end else begin
            we             = 1'b1;
            wd             = rd_word | bmask;
            count_nxt      = count_r + 11'd1;
            out_status_nxt = ST_OK;
          end
        end else begin
          if (!rd_word[idx_r[4:0]]) begin
            out_status_nxt = ST_INVALID;
          end else begin
            we             = 1'b1;
            wd             = rd_word & ~bmask;
            count_nxt      = count_r - 11'd1;
            out_status_nxt = ST_OK;
          end
        end
      end
      S_SCAN: begin
        if (carry_hit || in_hit) begin
          state_nxt = S_FPRE;
          start_nxt = found_start;
          end_nxt   = found_start + len_r - 11'd1;
        end else if (word_r == WA_W'(WORDS - 1)) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOSPACE;
          out_start_nxt  = '0;
        end else begin
          run_nxt  = (scan_w == '0) ? (run_r + 11'd32) : 11'(lz);
          addr_nxt = addr_r + WA_W'(1);
          word_nxt = word_r + WA_W'(1);
        end
      end
      S_FPRE: begin
        rd_addr   = start_w;
        addr_nxt  = start_w + WA_W'(1);
        word_nxt  = start_w;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        we = 1'b1;
        wa = word_r;
        wd = rd_word | fmask;
        if (word_r == end_w) begin
          state_nxt      = S_IDLE;
          count_nxt      = count_r + len_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_start_nxt  = start_r[9:0];
        end else begin
          addr_nxt = addr_r + WA_W'(1);
          word_nxt = word_r + WA_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        wvalid_r[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    len_r        <= len_nxt;
    addr_r       <= addr_nxt;
    word_r       <= word_nxt;
    run_r        <= run_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r  <= mem[rd_addr];
    rvalid_r <= wvalid_r[rd_addr];
  end

endmodule

### rtl/core/pbra_checker.sv
// ----------------------------------------------------------------------------
// Page bitmap run allocator checker
// Port-level checks of command acceptance, result timing and result values.
// ----------------------------------------------------------------------------
module pbra_checker #(
  parameter int ENTRIES = 1024
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input pbra_pkg::status_t out_status,
  input logic [9:0]        out_run_start,
  input logic [10:0]       out_allocated_count
);
  import pbra_pkg::*;

  // An accepted command either keeps the block busy or answers at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted command neither busy nor answered");

  // Leaving the busy state always comes with a result word.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_allocated_count <= 11'(ENTRIES))
    else $error("allocated count exceeds the number of entries");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_run_start == '0)
    else $error("failed command reports a nonzero run start");

endmodule

bind page_bitmap_run_allocator pbra_checker #(.ENTRIES(ENTRIES)) u_pbra_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_status          (out_status),
  .out_run_start       (out_run_start),
  .out_allocated_count (out_allocated_count)
);
